// ===== rtl/ddcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Drive command scheduler package
// Shared widths, the command type, queue control, ALU codes and helpers.
// ----------------------------------------------------------------------------
package ddcs_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int TIME_W  = 48;
    localparam int PEND_W  = 5;
    localparam int CFG_N   = 4;
    localparam int CFG_A_W = $clog2(CFG_N);
    localparam int CFG_D_W = 16;

    // Register indexes
    localparam logic [CFG_A_W-1:0] CFG_ACTION_DELAY = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_FWD      = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_MAX_REV      = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_MAX_STEER    = 2'd3;

    // Operation codes
    localparam logic [1:0] OP_SUBMIT    = 2'd0;
    localparam logic [1:0] OP_TICK      = 2'd1;
    localparam logic [1:0] OP_COLL_SET  = 2'd2;
    localparam logic [1:0] OP_COLL_CLR  = 2'd3;

    // Shared unit operation codes
    localparam logic [1:0] ALU_MUL = 2'd0;
    localparam logic [1:0] ALU_ADD = 2'd1;
    localparam logic [1:0] ALU_CMP = 2'd2;

    // Unit value in Q2.14
    localparam logic signed [16:0] Q_ONE = 17'sd16384;

    // One drive command as held in the queue
    typedef struct packed {
        logic [15:0]        speed;
        logic               rev;
        logic signed [15:0] steer;
    } t_cmd;

    // Control from the sequencer to the queue
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [IDX_W-1:0] idx;
    } t_queue_ctrl;

    // Clamp to plus or minus one and return the magnitude.
    function automatic logic [15:0] clamp_mag(input logic signed [16:0] v);
        logic signed [16:0] c;
        logic signed [16:0] m;
        begin
            if (v > Q_ONE) begin
                c = Q_ONE;
            end else if (v < -Q_ONE) begin
                c = -Q_ONE;
            end else begin
                c = v;
            end
            m = c[16] ? -c : c;
            return m[15:0];
        end
    endfunction

endpackage

// ===== rtl/ddcs_alu.sv =====
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Scaling multiply, saturating time add and time compare, one per cycle.
// ----------------------------------------------------------------------------
module ddcs_alu (
    input  logic [1:0]                  i_op,
    input  logic [ddcs_pkg::TIME_W-1:0] i_a,
    input  logic [ddcs_pkg::TIME_W-1:0] i_b,
    output logic [ddcs_pkg::TIME_W-1:0] o_res
);
    import ddcs_pkg::*;

    logic [31:0]       prod;
    logic [TIME_W:0]   sum;

    // Q2.14 scaling product and widened sum.
    assign prod = i_a[15:0] * i_b[15:0];
    assign sum  = {1'b0, i_a} + {1'b0, i_b};

    // Result selection; the add saturates at the top of the time range.
    always_comb begin
        case (i_op)
            ALU_MUL: o_res = {{(TIME_W - 16){1'b0}}, prod[29:14]};
            ALU_ADD: o_res = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            ALU_CMP: o_res = {{(TIME_W - 1){1'b0}}, (i_a <= i_b)};
            default: o_res = '0;
        endcase
    end

endmodule

// ===== rtl/ddcs_queue.sv =====
// ----------------------------------------------------------------------------
// Time-ordered command queue
// Register chain that opens a slot at one position or shifts towards the head.
// ----------------------------------------------------------------------------
module ddcs_queue (
    input  logic                        i_clk,
    input  ddcs_pkg::t_queue_ctrl       i_ctrl,
    input  logic [ddcs_pkg::IDX_W-1:0]  i_rd_idx,
    input  logic [ddcs_pkg::TIME_W-1:0] i_ins_due,
    input  ddcs_pkg::t_cmd              i_ins_cmd,
    output logic [ddcs_pkg::TIME_W-1:0] o_rd_due,
    output ddcs_pkg::t_cmd              o_rd_cmd
);
    import ddcs_pkg::*;

    logic [TIME_W-1:0] r_due [QUEUE_DEPTH];
    t_cmd              r_cmd [QUEUE_DEPTH];

    // On insert each cell above the slot takes its lower neighbour, on pop its upper one.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_ctrl.ins) begin
                if (32'(g) == 32'(i_ctrl.idx)) begin
                    r_due[g] <= i_ins_due;
                    r_cmd[g] <= i_ins_cmd;
                end else if (g > 0 && 32'(g) > 32'(i_ctrl.idx)) begin
                    r_due[g] <= r_due[(g > 0) ? g - 1 : 0];
                    r_cmd[g] <= r_cmd[(g > 0) ? g - 1 : 0];
                end
            end else if (i_ctrl.pop && g < QUEUE_DEPTH - 1) begin
                r_due[g] <= r_due[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                r_cmd[g] <= r_cmd[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    // Single read port for the scan and the head.
    assign o_rd_due = r_due[i_rd_idx];
    assign o_rd_cmd = r_cmd[i_rd_idx];

endmodule

// ===== rtl/delayed_drive_command_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Delayed drive command scheduler
// Scales drive actions and applies them from a time-ordered queue on ticks.
// ----------------------------------------------------------------------------
// Usage: one input transaction (i_in_valid, o_in_stall) carries an operation:
// submit an action, advance time by a tick, or set or clear the collision
// state. Every transaction gives one result transaction (o_out_valid,
// i_out_stall) with the applied command, the collision flag, the number of
// queued actions and a drop flag for a submit refused by a full queue.
// Sequencing: the block takes one transaction at a time and holds
// o_in_stall high while it works. A collision item goes straight to the
// result state; a submit scales speed and steer, adds the delay, then scans
// one queue entry per cycle for the insert position, or goes straight to the
// result state when the queue is full; a tick advances the clock, then
// applies the due entries from the head one per cycle. The next transaction
// can be taken in the cycle after the result is loaded. Each step uses a
// single shared multiply, add and compare unit, and the queue register chain
// moves one slot per cycle.
// Reset clears the clock, the queue fill, the active command, the collision
// state and the registers; queue contents are not cleared. If the receiver
// stalls, the result waits in the output register and the next input
// transaction is still accepted, but its result waits for the first.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data.
// ----------------------------------------------------------------------------
module delayed_drive_command_scheduler_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration
    input  logic                         i_cfg_we,
    input  logic [ddcs_pkg::CFG_A_W-1:0] i_cfg_index,
    input  logic [ddcs_pkg::CFG_D_W-1:0] i_cfg_data,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_operation,
    input  logic [ddcs_pkg::TIME_W-1:0]  i_action_time,
    input  logic signed [15:0]           i_norm_speed,
    input  logic                         i_reverse_request,
    input  logic signed [15:0]           i_norm_steer,
    input  logic [15:0]                  i_tick_dt,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [15:0]                  o_applied_speed,
    output logic                         o_applied_reverse,
    output logic signed [15:0]           o_cmd_steer,
    output logic                         o_collided_flag,
    output logic [ddcs_pkg::PEND_W-1:0]  o_pending_count,
    output logic                         o_dropped
);
    import ddcs_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPD   = 3'd1;
    localparam logic [2:0] S_STR   = 3'd2;
    localparam logic [2:0] S_DUE   = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_CLK   = 3'd5;
    localparam logic [2:0] S_APPLY = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Configuration registers
    logic [15:0] r_action_delay;
    logic [15:0] r_max_fwd;
    logic [15:0] r_max_rev;
    logic [14:0] r_max_steer;

    // Control state
    logic [2:0]        r_state, n_state;
    logic [TIME_W-1:0] r_clock;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    t_cmd              r_active;
    logic              r_coll;
    logic              r_dropped;

    // Latched item and working values
    logic [1:0]         r_op;
    logic [TIME_W-1:0]  r_time;
    logic signed [15:0] r_spd;
    logic               r_rev_req;
    logic signed [15:0] r_str;
    logic [15:0]        r_dt;
    logic [TIME_W-1:0]  r_due;
    t_cmd               r_new;

    // Shared unit and queue connections
    logic [1:0]        alu_op;
    logic [TIME_W-1:0] alu_a, alu_b, alu_res;
    t_queue_ctrl       q_ctrl;
    logic [IDX_W-1:0]  q_rd_idx;
    logic [TIME_W-1:0] q_rd_due;
    t_cmd              q_rd_cmd;

    logic               in_acc;
    logic               out_load;
    logic signed [16:0] spd_n;
    logic               spd_neg;
    logic [15:0]        spd_limit;
    logic [15:0]        spd_mag;
    logic [15:0]        str_mag;
    logic signed [15:0] str_mag_s;
    logic               at_end;
    logic               le;
    logic [31:0]        fill_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!o_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE);

    // Speed request after reverse negation and limit selection.
    assign spd_n     = r_rev_req ? -17'(r_spd) : 17'(r_spd);
    assign spd_neg   = spd_n[16];
    assign spd_limit = spd_neg ? r_max_rev : r_max_fwd;
    assign spd_mag   = clamp_mag(spd_n);
    assign str_mag   = clamp_mag(17'(r_str));
    assign str_mag_s = $signed(alu_res[15:0]);

    assign le     = alu_res[0];
    assign at_end = (r_idx == r_fill);

    // Operand selection for the shared unit.
    always_comb begin
        case (r_state)
            S_SPD: begin
                alu_op = ALU_MUL;
                alu_a  = TIME_W'(spd_mag);
                alu_b  = TIME_W'(spd_limit);
            end
            S_STR: begin
                alu_op = ALU_MUL;
                alu_a  = TIME_W'(str_mag);
                alu_b  = TIME_W'(r_max_steer);
            end
            S_DUE: begin
                alu_op = ALU_ADD;
                alu_a  = r_time;
                alu_b  = TIME_W'(r_action_delay);
            end
            S_CLK: begin
                alu_op = ALU_ADD;
                alu_a  = r_clock;
                alu_b  = TIME_W'(r_dt);
            end
            S_FIND: begin
                alu_op = ALU_CMP;
                alu_a  = q_rd_due;
                alu_b  = r_due;
            end
            S_APPLY: begin
                alu_op = ALU_CMP;
                alu_a  = q_rd_due;
                alu_b  = r_clock;
            end
            default: begin
                alu_op = ALU_MUL;
                alu_a  = '0;
                alu_b  = '0;
            end
        endcase
    end

    ddcs_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Queue read position: the head while applying, the scan position otherwise.
    assign q_rd_idx = (r_state == S_APPLY) ? '0 : r_idx[IDX_W-1:0];

    // Queue control: insert at the scan position, pop from the head.
    always_comb begin
        q_ctrl.ins = (r_state == S_FIND) && (at_end || !le);
        q_ctrl.pop = (r_state == S_APPLY) && (r_fill != '0) && le;
        q_ctrl.idx = q_rd_idx;
    end

    ddcs_queue u_queue (
        .i_clk     (i_clk),
        .i_ctrl    (q_ctrl),
        .i_rd_idx  (q_rd_idx),
        .i_ins_due (r_due),
        .i_ins_cmd (r_new),
        .o_rd_due  (q_rd_due),
        .o_rd_cmd  (q_rd_cmd)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_operation)
                        OP_SUBMIT: n_state = S_SPD;
                        OP_TICK:   n_state = S_CLK;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SPD:   n_state = S_STR;
            S_STR:   n_state = S_DUE;
            S_DUE:   n_state = (32'(r_fill) >= QUEUE_DEPTH) ? S_DONE : S_FIND;
            S_FIND:  n_state = (at_end || !le) ? S_DONE : S_FIND;
            S_CLK:   n_state = S_APPLY;
            S_APPLY: n_state = q_ctrl.pop ? S_APPLY : S_DONE;
            S_DONE:  n_state = out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action_delay <= '0;
            r_max_fwd      <= '0;
            r_max_rev      <= '0;
            r_max_steer    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTION_DELAY: r_action_delay <= i_cfg_data;
                CFG_MAX_FWD:      r_max_fwd      <= i_cfg_data;
                CFG_MAX_REV:      r_max_rev      <= i_cfg_data;
                CFG_MAX_STEER:    r_max_steer    <= i_cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_clock  <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
            r_active <= '0;
            r_coll   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_operation == OP_COLL_SET) begin
                        r_coll <= 1'b1;
                    end else if (in_acc && i_operation == OP_COLL_CLR) begin
                        r_coll <= 1'b0;
                    end
                    r_idx <= '0;
                end
                S_CLK: r_clock <= alu_res;
                S_FIND: begin
                    if (q_ctrl.ins) begin
                        r_fill <= r_fill + 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_APPLY: begin
                    if (q_ctrl.pop) begin
                        r_active <= q_rd_cmd;
                        r_fill   <= r_fill - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item and working registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_op      <= i_operation;
                    r_time    <= i_action_time;
                    r_spd     <= i_norm_speed;
                    r_rev_req <= i_reverse_request;
                    r_str     <= i_norm_steer;
                    r_dt      <= i_tick_dt;
                    r_dropped <= 1'b0;
                end
            end
            S_SPD: begin
                r_new.speed <= alu_res[15:0];
                r_new.rev   <= spd_neg && (spd_limit != '0);
            end
            S_STR: r_new.steer <= (r_str < 0) ? -str_mag_s : str_mag_s;
            S_DUE: begin
                r_due     <= alu_res;
                r_dropped <= (32'(r_fill) >= QUEUE_DEPTH) && (r_op == OP_SUBMIT);
            end
            default: ;
        endcase
    end

    // Result register, with forward speed gated while in collision.
    assign fill_ext = 32'(r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_applied_speed   <= (r_coll && !r_active.rev) ? 16'd0 : r_active.speed;
            o_applied_reverse <= r_active.rev;
            o_cmd_steer       <= r_active.steer;
            o_collided_flag   <= r_coll;
            o_pending_count   <= fill_ext[PEND_W-1:0];
            o_dropped         <= r_dropped;
        end
    end

    // Checks on the sequencer and the queue.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= QUEUE_DEPTH)
        else $error("queue fill beyond depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken without going busy");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ctrl.ins |-> (32'(r_fill) < QUEUE_DEPTH))
        else $error("insert into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ctrl.pop |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("pop did not lower the fill");

endmodule

// ===== bench/drive_cmd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive command checker
// Watches both channels of the scheduler, keeps its own copy of the queue,
// clock, collision state and registers, predicts the applied command for
// every accepted input transaction and compares each result transaction with
// the oldest prediction.
// ----------------------------------------------------------------------------
module drive_cmd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration port as seen by the block
    input  logic                           i_cfg_we,
    input  logic [ddcs_pkg::CFG_A_W-1:0]   i_cfg_index,
    input  logic [ddcs_pkg::CFG_D_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [1:0]                     i_operation,
    input  logic [ddcs_pkg::TIME_W-1:0]    i_action_time,
    input  logic signed [15:0]             i_norm_speed,
    input  logic                           i_reverse_request,
    input  logic signed [15:0]             i_norm_steer,
    input  logic [15:0]                    i_tick_dt,
    // Output channel
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [15:0]                    i_applied_speed,
    input  logic                           i_applied_reverse,
    input  logic signed [15:0]             i_cmd_steer,
    input  logic                           i_collided_flag,
    input  logic [ddcs_pkg::PEND_W-1:0]    i_pending_count,
    input  logic                           i_dropped,
    // Status for the testbench top
    output int                             o_fail_count,
    output int                             o_results_due
);
    import ddcs_pkg::*;

    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

    // One expected result transaction.
    typedef struct packed {
        logic [15:0]        speed;
        logic               rev;
        logic signed [15:0] steer;
        logic               collided;
        logic [PEND_W-1:0]  pending;
        logic               dropped;
    } t_drive_result;

    // Register copies
    logic [15:0] delay_reg;
    logic [15:0] fwd_limit;
    logic [15:0] rev_limit;
    logic [14:0] steer_limit;

    // Scheduler state copies
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] due_at [QUEUE_DEPTH];
    t_cmd              held_cmd [QUEUE_DEPTH];
    int                fill;
    t_cmd              applied;
    logic              collided;

    t_drive_result     predicted_cmds [$];
    int                mismatches;

    // Time addition that sticks at the top of the 48-bit range.
    function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_TOP : s[TIME_W-1:0];
    endfunction

    // Limit a Q2.14 value to plus or minus one.
    function automatic logic signed [16:0] clamp_unit(input logic signed [16:0] v);
        if (v > 17'sd16384) begin
            return 17'sd16384;
        end else if (v < -17'sd16384) begin
            return -17'sd16384;
        end
        return v;
    endfunction

    // Truncated magnitude of a clamped value times a limit, back to the limit's scale.
    function automatic logic [15:0] scaled_mag(input logic signed [16:0] v,
                                               input logic [15:0] lim);
        logic [16:0] m;
        logic [32:0] prod;
        m = v[16] ? -v : v;
        prod = m * lim;
        return prod[29:14];
    endfunction

    // Advances the state copy by one item and works out its result.
    task automatic predict_command(input logic [1:0] op, input logic [TIME_W-1:0] ts,
                                   input logic signed [15:0] spd, input logic rev_req,
                                   input logic signed [15:0] str, input logic [15:0] dt,
                                   output t_drive_result r);
        t_cmd               c;
        logic signed [16:0] n;
        logic signed [16:0] s;
        logic [15:0]        lim;
        logic [15:0]        smag;
        logic [TIME_W-1:0]  due;
        int                 p;
        int                 k;
        r.dropped = 1'b0;
        case (op)
            OP_SUBMIT: begin
                // Scale the request; the sign after the reverse request picks the limit.
                n = {spd[15], spd};
                if (rev_req) begin
                    n = -n;
                end
                lim = n[16] ? rev_limit : fwd_limit;
                n = clamp_unit(n);
                c.speed = scaled_mag(n, lim);
                c.rev = n[16] && (lim != 16'd0);
                s = clamp_unit({str[15], str});
                smag = scaled_mag(s, {1'b0, steer_limit});
                c.steer = s[16] ? -smag : smag;
                due = add_sat(ts, {32'd0, delay_reg});
                if (fill >= QUEUE_DEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    // A new entry goes behind every entry with an equal due time.
                    p = 0;
                    while (p < fill && due_at[p] <= due) begin
                        p++;
                    end
                    for (int i = fill; i > p; i--) begin
                        due_at[i] = due_at[i-1];
                        held_cmd[i] = held_cmd[i-1];
                    end
                    due_at[p] = due;
                    held_cmd[p] = c;
                    fill++;
                end
            end
            OP_TICK: begin
                // Apply everything now due; the last of them wins.
                clock_now = add_sat(clock_now, {32'd0, dt});
                k = 0;
                while (k < fill && due_at[k] <= clock_now) begin
                    k++;
                end
                if (k > 0) begin
                    applied = held_cmd[k-1];
                    for (int i = k; i < fill; i++) begin
                        due_at[i-k] = due_at[i];
                        held_cmd[i-k] = held_cmd[i];
                    end
                    fill -= k;
                end
            end
            OP_COLL_SET: begin
                collided = 1'b1;
            end
            OP_COLL_CLR: begin
                collided = 1'b0;
            end
            default: begin
            end
        endcase
        // Forward motion is held at zero while in collision.
        r.speed = (collided && !applied.rev) ? 16'd0 : applied.speed;
        r.rev = applied.rev;
        r.steer = applied.steer;
        r.collided = collided;
        r.pending = PEND_W'(fill);
    endtask

    // Reports one differing field and returns how many failures it adds.
    function automatic int field_differs(input string name, input logic [15:0] want_v,
                                         input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%h, got 0x%h", name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    // Channel monitor: registers, then results, then new items.
    always @(posedge i_clk) begin : watch
        t_drive_result want;
        if (!i_rst_n) begin
            delay_reg = '0;
            fwd_limit = '0;
            rev_limit = '0;
            steer_limit = '0;
            clock_now = '0;
            fill = 0;
            applied = '0;
            collided = 1'b0;
            mismatches = 0;
            predicted_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTION_DELAY: delay_reg = i_cfg_data;
                    CFG_MAX_FWD:      fwd_limit = i_cfg_data;
                    CFG_MAX_REV:      rev_limit = i_cfg_data;
                    CFG_MAX_STEER:    steer_limit = i_cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (predicted_cmds.size() == 0) begin
                    $error("result transaction with no item waiting for it");
                    mismatches++;
                end else begin
                    want = predicted_cmds.pop_front();
                    mismatches += field_differs("applied_speed", want.speed,
                                                i_applied_speed);
                    mismatches += field_differs("applied_reverse", 16'(want.rev),
                                                16'(i_applied_reverse));
                    mismatches += field_differs("cmd_steer", want.steer, i_cmd_steer);
                    mismatches += field_differs("collided_flag", 16'(want.collided),
                                                16'(i_collided_flag));
                    mismatches += field_differs("pending_count", 16'(want.pending),
                                                16'(i_pending_count));
                    mismatches += field_differs("dropped", 16'(want.dropped), 16'(i_dropped));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_command(i_operation, i_action_time, i_norm_speed, i_reverse_request,
                                i_norm_steer, i_tick_dt, want);
                predicted_cmds.insert(predicted_cmds.size(), want);
            end
        end
        o_fail_count <= mismatches;
        o_results_due <= predicted_cmds.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive command scheduler testbench
// Drives directed and random submit, tick and collision transactions through
// several register settings, with random idling on both channels, one long
// receiver hold-off and a drain between phases. The checker does all the
// prediction; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import ddcs_pkg::*;

    localparam int     CYCLE_LIMIT = 200000;
    localparam int     LONG_HOLD   = 300;
    localparam int     HOLD_AT     = 150;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     PHASE_ITEMS = 75;
    localparam longint TIME_TOP    = 64'hFFFF_FFFF_FFFF;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  cfg_index = '0;
    logic [CFG_D_W-1:0]  cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          in_operation = OP_COLL_CLR;
    logic [TIME_W-1:0]   in_action_time = '0;
    logic signed [15:0]  in_norm_speed = '0;
    logic                in_reverse_request = 1'b0;
    logic signed [15:0]  in_norm_steer = '0;
    logic [15:0]         in_tick_dt = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [15:0]         applied_speed;
    logic                applied_reverse;
    logic signed [15:0]  cmd_steer;
    logic                collided_flag;
    logic [PEND_W-1:0]   pending_count;
    logic                dropped;

    int                  fail_count;
    int                  results_due;
    logic                no_idle = 1'b0;
    longint              clock_guess = 0;
    int                  cycle_count = 0;
    int                  hold_left = 0;
    int                  results_taken = 0;
    logic                long_done = 1'b0;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    delayed_drive_command_scheduler_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (in_operation),
        .i_action_time     (in_action_time),
        .i_norm_speed      (in_norm_speed),
        .i_reverse_request (in_reverse_request),
        .i_norm_steer      (in_norm_steer),
        .i_tick_dt         (in_tick_dt),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_applied_speed   (applied_speed),
        .o_applied_reverse (applied_reverse),
        .o_cmd_steer       (cmd_steer),
        .o_collided_flag   (collided_flag),
        .o_pending_count   (pending_count),
        .o_dropped         (dropped)
    );

    drive_cmd_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_operation       (in_operation),
        .i_action_time     (in_action_time),
        .i_norm_speed      (in_norm_speed),
        .i_reverse_request (in_reverse_request),
        .i_norm_steer      (in_norm_steer),
        .i_tick_dt         (in_tick_dt),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_applied_speed   (applied_speed),
        .i_applied_reverse (applied_reverse),
        .i_cmd_steer       (cmd_steer),
        .i_collided_flag   (collided_flag),
        .i_pending_count   (pending_count),
        .i_dropped         (dropped),
        .o_fail_count      (fail_count),
        .o_results_due     (results_due)
    );

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[delayed_drive_command_scheduler_unit] ERROR");
            $finish;
        end
    end

    // Receiver: a random hold after each result transaction, and one long
    // hold-off part way through so that the block backs up onto its input.
    always @(posedge clk) begin : receiver
        int hold;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else if (out_valid && !out_stall) begin
            results_taken <= results_taken + 1;
            if (!long_done && results_taken == HOLD_AT) begin
                hold = LONG_HOLD;
                long_done <= 1'b1;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 13);
            end
            hold_left <= hold;
            out_stall <= (hold != 0);
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end
    end

    // Offers one input transaction after a random gap and waits until it is taken.
    task automatic send_item(input logic [1:0] op, input logic [TIME_W-1:0] ts,
                             input logic [15:0] spd, input logic rev, input logic [15:0] str,
                             input logic [15:0] dt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_operation <= op;
        in_action_time <= ts;
        in_norm_speed <= spd;
        in_reverse_request <= rev;
        in_norm_steer <= str;
        in_tick_dt <= dt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Fields that an operation ignores always carry random values.
    task automatic submit(input longint ts, input logic [15:0] spd, input logic rev,
                          input logic [15:0] str);
        send_item(OP_SUBMIT, ts[TIME_W-1:0], spd, rev, str, 16'($urandom));
    endtask

    task automatic tick(input logic [15:0] dt);
        send_item(OP_TICK, {16'($urandom), 32'($urandom)}, 16'($urandom), 1'($urandom),
                  16'($urandom), dt);
        clock_guess = clock_guess + dt;
        if (clock_guess > TIME_TOP) begin
            clock_guess = TIME_TOP;
        end
    endtask

    task automatic collide(input logic [1:0] op);
        send_item(op, {16'($urandom), 32'($urandom)}, 16'($urandom), 1'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
    endtask

    // Writes all four registers, one per cycle, while the block is idle.
    task automatic load_registers(input logic [15:0] delay_v, input logic [15:0] fwd_v,
                                  input logic [15:0] rev_v, input logic [14:0] steer_v);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ACTION_DELAY;
        cfg_data <= delay_v;
        @(posedge clk);
        cfg_index <= CFG_MAX_FWD;
        cfg_data <= fwd_v;
        @(posedge clk);
        cfg_index <= CFG_MAX_REV;
        cfg_data <= rev_v;
        @(posedge clk);
        cfg_index <= CFG_MAX_STEER;
        cfg_data <= {1'b0, steer_v};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Normalised request, often at an extreme or on the clamp boundary.
    function automatic logic [15:0] pick_norm();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'hC000;
            2: return 16'h4000;
            3: return 16'h7FFF;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int         phase;
        int         sent;
        int         pick;
        int         dt_max;
        longint     ts;
        logic [15:0] delay_v;
        logic [15:0] fwd_v;
        logic [15:0] rev_v;
        logic [14:0] steer_v;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Limits still at reset: everything scales to zero, no reverse flag.
        submit(0, 16'h4000, 1'b0, 16'h4000);
        submit(0, 16'hC000, 1'b0, 16'hC000);
        tick(16'd0);
        wait_drained();

        // Full limits: clamping at both ends and the reverse request.
        load_registers(16'd0, 16'hFFFF, 16'hFFFF, 15'h7FFF);
        submit(clock_guess, 16'h7FFF, 1'b0, 16'h8000);
        submit(clock_guess + 1, 16'h8000, 1'b1, 16'h7FFF);
        submit(clock_guess + 2, 16'h8000, 1'b0, 16'h0001);
        tick(16'd1);
        tick(16'd1);

        // Equal due times apply in insertion order.
        submit(clock_guess + 10, 16'h2000, 1'b0, 16'd100);
        submit(clock_guess + 10, 16'hF000, 1'b0, 16'hFF9C);
        submit(clock_guess + 9, 16'h0001, 1'b1, 16'h0000);
        tick(16'hFFFF);

        // Collision gates forward speed only; a tick with nothing due keeps the command.
        collide(OP_COLL_SET);
        submit(clock_guess, 16'h4000, 1'b0, 16'h1234);
        tick(16'd0);
        collide(OP_COLL_SET);
        collide(OP_COLL_CLR);
        tick(16'd0);
        wait_drained();

        // Largest delay: the due time saturates; zero reverse limit gives no reverse flag.
        load_registers(16'hFFFF, 16'($urandom), 16'd0, 15'd0);
        submit(TIME_TOP - 5, pick_norm(), 1'b0, pick_norm());
        submit(clock_guess, 16'hD8F0, 1'b0, 16'h3000);
        tick(16'hFFFF);
        tick(16'd2);
        wait_drained();

        // Random phases, each under its own register setting.
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    delay_v = 16'd0;
                    fwd_v = 16'hFFFF;
                    rev_v = 16'hFFFF;
                    steer_v = 15'h7FFF;
                end
                1: begin
                    delay_v = 16'd0;
                    fwd_v = 16'd0;
                    rev_v = 16'd0;
                    steer_v = 15'd0;
                end
                4: begin
                    delay_v = 16'hFFFF;
                    fwd_v = 16'($urandom);
                    rev_v = 16'($urandom);
                    steer_v = 15'($urandom);
                end
                5: begin
                    delay_v = 16'($urandom_range(0, 2000));
                    fwd_v = 16'($urandom);
                    rev_v = 16'($urandom);
                    steer_v = 15'($urandom);
                end
                default: begin
                    delay_v = 16'($urandom_range(0, 400));
                    fwd_v = 16'($urandom);
                    rev_v = 16'($urandom);
                    steer_v = 15'($urandom);
                end
            endcase
            load_registers(delay_v, fwd_v, rev_v, steer_v);
            no_idle <= (phase == 3);
            dt_max = delay_v / 4 + 64;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    // A burst of submits overfills the queue.
                    repeat (18) begin
                        submit(clock_guess + $urandom_range(0, 4 * dt_max), pick_norm(),
                               1'($urandom_range(0, 1)), pick_norm());
                    end
                    sent += 18;
                end else if (pick < 55) begin
                    ts = clock_guess + $urandom_range(0, 4 * dt_max);
                    if ($urandom_range(0, 3) == 0) begin
                        ts = clock_guess - ((clock_guess > 64) ? $urandom_range(0, 64) : 0);
                    end
                    submit(ts, pick_norm(), 1'($urandom_range(0, 1)), pick_norm());
                    sent++;
                end else if (pick < 88) begin
                    if ($urandom_range(0, 19) == 0) begin
                        tick(16'($urandom));
                    end else begin
                        tick(16'($urandom_range(0, dt_max)));
                    end
                    sent++;
                end else begin
                    collide(($urandom_range(0, 1) == 1) ? OP_COLL_SET : OP_COLL_CLR);
                    sent++;
                end
            end
            wait_drained();
        end

        // Let any late result show up before the verdict.
        no_idle <= 1'b0;
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("[delayed_drive_command_scheduler_unit] OK");
        end else begin
            $display("[delayed_drive_command_scheduler_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== delayed_drive_command_scheduler_unit.f =====
rtl/ddcs_pkg.sv
rtl/ddcs_alu.sv
rtl/ddcs_queue.sv
rtl/delayed_drive_command_scheduler_unit.sv
bench/drive_cmd_checker.sv
bench/tb.sv
